// ===== hdl/lru_cache_with_pinning_core_assert.svh =====
// Assertion macros used by the checker file of the cache block.
`ifndef LRU_CACHE_WITH_PINNING_CORE_ASSERT_SVH
`define LRU_CACHE_WITH_PINNING_CORE_ASSERT_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define LCP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an antecedent implies a consequent on the next edge.
`define LCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/lcp_pkg.sv =====
// Package with types, constants and status codes of the pinning LRU cache.
`default_nettype none
package lcp_pkg;
  localparam int LCP_ENTRIES    = 16;
  localparam int LCP_KEY_BITS   = 32;
  localparam int LCP_VALUE_BITS = 32;
  localparam int LCP_PIN_BITS   = 8;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_UNLOCK = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_ALL_PINNED = 3'd2;
  localparam logic [2:0] ST_PINNED     = 3'd3;
  localparam logic [2:0] ST_UNPINNED   = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value_in;
    logic        take_lock;
    logic        refresh;
    logic [3:0]  slot_in;
  } lcp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [3:0]  slot_out;
    logic        evicted;
    logic [31:0] evicted_key;
  } lcp_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic search;   // register key match, victim and free slot
    logic execute;  // apply the command and build the result
  } lcp_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/lcp_ctrl.sv =====
// Controller state machine sequencing one command through the datapath.
`default_nettype none
module lcp_ctrl
  import lcp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lcp_cmd_t      dp_cmd
);
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_EXEC   = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt      = state_r;
    dp_cmd.load    = 1'b0;
    dp_cmd.search  = 1'b0;
    dp_cmd.execute = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        dp_cmd.search = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        dp_cmd.execute = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/lcp_dp.sv =====
// Datapath: entry table, key match, victim search and recency update.
`default_nettype none
module lcp_dp
  import lcp_pkg::*;
#(
  parameter int ENTRIES    = LCP_ENTRIES,
  parameter int KEY_BITS   = LCP_KEY_BITS,
  parameter int VALUE_BITS = LCP_VALUE_BITS,
  parameter int PIN_BITS   = LCP_PIN_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lcp_cmd_t dp_cmd,
  input  wire lcp_in_t  in_data,
  input  wire logic [4:0] capacity,
  output lcp_out_t      out_data
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] value_r [ENTRIES];
  logic [PIN_BITS-1:0]   pin_r   [ENTRIES];
  logic [IW-1:0]         rank_r  [ENTRIES];
  logic [CW-1:0]         count_r;

  lcp_in_t               req_r;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;

  // Search results, registered between the search and execute steps.
  logic          hit_r, vic_ok_r, free_ok_r, full_r;
  logic [IW-1:0] hit_idx_r, vic_idx_r, free_idx_r;

  logic          hit_c, vic_ok_c, free_ok_c;
  logic [IW-1:0] hit_idx_c, vic_idx_c, free_idx_c, best_c;
  logic [CW-1:0] cap_eff;

  // Table state after the execute step.
  logic [ENTRIES-1:0]    valid_nxt;
  logic [PIN_BITS-1:0]   pin_nxt  [ENTRIES];
  logic [IW-1:0]         rank_nxt [ENTRIES];
  logic [CW-1:0]         count_nxt;
  lcp_out_t              out_nxt;
  logic                  val_we, key_we;
  logic [IW-1:0]         wr_idx;
  logic [IW-1:0]         r_hit, r_vic, new_idx;
  logic [PIN_BITS-1:0]   p_hit;

  assign req_key = KEY_BITS'(req_r.key);
  assign req_val = VALUE_BITS'(req_r.value_in);

  always_comb begin
    if (capacity == 5'd0) cap_eff = CW'(1);
    else if ({27'd0, capacity} > ENTRIES) cap_eff = CW'(ENTRIES);
    else cap_eff = CW'(capacity);
  end

  // Priority search: lowest matching slot, oldest unpinned slot, lowest free.
  always_comb begin
    hit_c = 1'b0; hit_idx_c = '0;
    vic_ok_c = 1'b0; vic_idx_c = '0; best_c = '0;
    free_ok_c = 1'b0; free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == req_key) begin
        hit_c = 1'b1; hit_idx_c = IW'(i);
      end
      if (!valid_r[i]) begin
        free_ok_c = 1'b1; free_idx_c = IW'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && pin_r[i] == '0 && (!vic_ok_c || rank_r[i] > best_c)) begin
        vic_ok_c = 1'b1; vic_idx_c = IW'(i); best_c = rank_r[i];
      end
    end
  end

  logic [IW-1:0]         slot_sel;
  logic                  slot_ok;
  logic [PIN_BITS-1:0]   slot_pin;

  assign slot_sel = IW'(req_r.slot_in);
  assign slot_ok  = ({28'd0, req_r.slot_in} < ENTRIES);
  assign slot_pin = pin_r[slot_sel];

  always_ff @(posedge clk) begin
    if (dp_cmd.load) req_r <= in_data;
    if (dp_cmd.search) begin
      hit_r <= hit_c; hit_idx_r <= hit_idx_c;
      vic_ok_r <= vic_ok_c; vic_idx_r <= vic_idx_c;
      free_ok_r <= free_ok_c; free_idx_r <= free_idx_c;
      full_r <= (count_r >= cap_eff);
    end
  end

  assign r_hit = rank_r[hit_idx_r];
  assign r_vic = rank_r[vic_idx_r];
  assign p_hit = pin_r[hit_idx_r];
  // After an eviction the lowest free slot is the lower of victim and prior free.
  assign new_idx = (free_ok_r && free_idx_r < vic_idx_r) ? free_idx_r : vic_idx_r;

  // Execute step: the command applied to the table and the result it gives.
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      pin_nxt[i]  = pin_r[i];
      rank_nxt[i] = rank_r[i];
    end
    val_we  = 1'b0;
    key_we  = 1'b0;
    wr_idx  = hit_idx_r;
    out_nxt = '0;
    case (req_r.cmd)
      CMD_ADD: begin
        if (hit_r) begin
          val_we = 1'b1;
          for (int i = 0; i < ENTRIES; i++)
            if (valid_r[i] && rank_r[i] < r_hit) rank_nxt[i] = rank_r[i] + 1'b1;
          rank_nxt[hit_idx_r] = '0;
          if (req_r.take_lock && p_hit != '1) pin_nxt[hit_idx_r] = p_hit + 1'b1;
          out_nxt.slot_out = 4'(hit_idx_r);
        end else if (full_r && !vic_ok_r) begin
          out_nxt.status = ST_ALL_PINNED;
        end else if (full_r) begin
          // Entries younger than the victim age by one; older ones keep their rank.
          out_nxt.evicted     = 1'b1;
          out_nxt.evicted_key = 32'(key_r[vic_idx_r]);
          for (int i = 0; i < ENTRIES; i++)
            if (valid_r[i] && IW'(i) != vic_idx_r && rank_r[i] < r_vic)
              rank_nxt[i] = rank_r[i] + 1'b1;
          valid_nxt[vic_idx_r] = 1'b0;
          pin_nxt[vic_idx_r]   = '0;
          rank_nxt[vic_idx_r]  = '0;
          valid_nxt[new_idx]   = 1'b1;
          rank_nxt[new_idx]    = '0;
          pin_nxt[new_idx]     = req_r.take_lock ? PIN_BITS'(1) : '0;
          val_we = 1'b1;
          key_we = 1'b1;
          wr_idx = new_idx;
          out_nxt.slot_out = 4'(new_idx);
        end else if (!free_ok_r) begin
          out_nxt.status = ST_ALL_PINNED;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid_r[i]) rank_nxt[i] = rank_r[i] + 1'b1;
          valid_nxt[free_idx_r] = 1'b1;
          rank_nxt[free_idx_r]  = '0;
          pin_nxt[free_idx_r]   = req_r.take_lock ? PIN_BITS'(1) : '0;
          count_nxt = count_r + 1'b1;
          val_we = 1'b1;
          key_we = 1'b1;
          wr_idx = free_idx_r;
          out_nxt.slot_out = 4'(free_idx_r);
        end
      end
      CMD_LOOKUP: begin
        if (!hit_r) begin
          out_nxt.status = ST_MISS;
        end else begin
          out_nxt.value_out = 32'(value_r[hit_idx_r]);
          out_nxt.slot_out  = 4'(hit_idx_r);
          if (req_r.take_lock && p_hit != '1) pin_nxt[hit_idx_r] = p_hit + 1'b1;
          if (req_r.refresh) begin
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] < r_hit) rank_nxt[i] = rank_r[i] + 1'b1;
            rank_nxt[hit_idx_r] = '0;
          end
        end
      end
      CMD_REMOVE: begin
        if (!hit_r) begin
          out_nxt.status = ST_MISS;
        end else if (p_hit != '0) begin
          out_nxt.status   = ST_PINNED;
          out_nxt.slot_out = 4'(hit_idx_r);
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid_r[i] && rank_r[i] > r_hit) rank_nxt[i] = rank_r[i] - 1'b1;
          valid_nxt[hit_idx_r] = 1'b0;
          rank_nxt[hit_idx_r]  = '0;
          if (count_r != '0) count_nxt = count_r - 1'b1;
          out_nxt.slot_out = 4'(hit_idx_r);
        end
      end
      CMD_UNLOCK: begin
        if (!slot_ok || !valid_r[slot_sel] || slot_pin == '0) begin
          out_nxt.status = ST_UNPINNED;
        end else begin
          pin_nxt[slot_sel] = slot_pin - 1'b1;
          out_nxt.slot_out  = req_r.slot_in;
        end
      end
      default: out_nxt.status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        pin_r[i]  <= '0;
        rank_r[i] <= '0;
      end
    end else if (dp_cmd.execute) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        pin_r[i]  <= pin_nxt[i];
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      out_data <= out_nxt;
      if (val_we) value_r[wr_idx] <= req_val;
      if (key_we) key_r[wr_idx] <= req_key;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lru_cache_with_pinning_core.sv =====
// Top level of the pinning LRU key/value cache.
// The input channel (in_valid, in_stall, in_data) carries one command beat:
// add, lookup, remove or unlock by slot. The result channel (out_valid,
// out_stall, out_data) returns exactly one result beat per command.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// capacity register; it is always ready and should be used while idle.
// Each command goes through four steps: capture, a match and victim search
// over all entries in parallel that is registered, an execute step that
// updates the table and recency ranks, and a state presenting the result.
// One command is in flight at a time, so in_stall is high from capture until
// the result beat is taken; no new command is accepted before then. A stalled
// result simply holds out_data and keeps in_stall high. Synchronous active-low
// reset empties the cache, clears all pin counts and ranks and sets capacity
// to its full value.
`default_nettype none
module lru_cache_with_pinning_core
  import lcp_pkg::*;
#(
  parameter int ENTRIES    = LCP_ENTRIES,
  parameter int KEY_BITS   = LCP_KEY_BITS,
  parameter int VALUE_BITS = LCP_VALUE_BITS,
  parameter int PIN_BITS   = LCP_PIN_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire lcp_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output lcp_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data
);
  lcp_cmd_t   dp_cmd;
  logic [4:0] capacity_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= 5'd16;
    else if (cfg_valid) capacity_r <= cfg_data;
  end

  lcp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .dp_cmd
  );

  lcp_dp #(
    .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS), .PIN_BITS(PIN_BITS)
  ) u_dp (
    .clk, .rst_n, .dp_cmd, .in_data, .capacity(capacity_r), .out_data
  );
endmodule
`default_nettype wire

// ===== hdl/lcp_checker.sv =====
// Port-level checker for the cache top level, bound to it.
`default_nettype none
`include "lru_cache_with_pinning_core_assert.svh"
module lcp_checker
  import lcp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lcp_out_t out_data
);
  `LCP_ASSERT_NEXT(a_accept_stalls, clk, rst_n, in_valid && !in_stall, in_stall, "accept not followed by stall")
  `LCP_ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, in_stall, "result shown while input open")
  `LCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `LCP_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_data.status <= ST_UNPINNED, "bad status")
  `LCP_ASSERT_IMPL(a_evict_ok, clk, rst_n, out_valid && out_data.evicted, out_data.status == ST_OK, "eviction with error")
endmodule
bind lru_cache_with_pinning_core lcp_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

// ===== bench/lru_cache_with_pinning_core_tb.sv =====
// Self-checking testbench for the pinning LRU key/value cache core.
`timescale 1ns / 1ps
module lru_cache_with_pinning_core_tb;
  import lcp_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  lcp_in_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  lcp_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [4:0] cfg_data;

  lru_cache_with_pinning_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // The clock runs at a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the cache table, kept in step with every accepted command.
  logic        tbl_valid [LCP_ENTRIES];
  logic [31:0] tbl_key   [LCP_ENTRIES];
  logic [31:0] tbl_value [LCP_ENTRIES];
  int unsigned tbl_pins  [LCP_ENTRIES];
  int unsigned tbl_age   [LCP_ENTRIES];
  int unsigned tbl_count;
  logic [4:0]  cap_setting;

  lcp_out_t    pending_results[$];
  int          errors = 0;
  logic [31:0] key_pool[24];

  // Receiver controls: a long hold-off, a random stall burst, and a quiet flag
  // that switches all idling off for the last part of the run.
  logic hold_on = 1'b0;
  int   stall_left = 0;
  logic quiet;

  function automatic int unsigned cap_limit();
    if (cap_setting == 0) return 1;
    if (cap_setting > LCP_ENTRIES) return LCP_ENTRIES;
    return cap_setting;
  endfunction

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < LCP_ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  // Make a slot the newest; everything younger than it ages by one.
  function automatic void make_newest(int s);
    int unsigned r;
    r = tbl_age[s];
    for (int i = 0; i < LCP_ENTRIES; i++)
      if (tbl_valid[i] && i != s && tbl_age[i] < r) tbl_age[i]++;
    tbl_age[s] = 0;
  endfunction

  // Free a slot; everything older than it moves one step younger.
  function automatic void free_slot(int s);
    int unsigned r;
    r = tbl_age[s];
    tbl_valid[s] = 1'b0;
    tbl_pins[s] = 0;
    tbl_age[s] = 0;
    for (int i = 0; i < LCP_ENTRIES; i++)
      if (tbl_valid[i] && tbl_age[i] > r) tbl_age[i]--;
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic void add_pin(int s);
    if (tbl_pins[s] < (1 << LCP_PIN_BITS) - 1) tbl_pins[s]++;
  endfunction

  // Apply one command to the shadow table and return the result it must give.
  function automatic lcp_out_t cache_response(lcp_in_t it);
    lcp_out_t    r;
    int          s;
    int          victim;
    int unsigned oldest;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_ADD: begin
        s = find_slot(it.key);
        if (s >= 0) begin
          // A repeated add overwrites the value and refreshes the entry.
          tbl_value[s] = it.value_in;
          make_newest(s);
          if (it.take_lock) add_pin(s);
          r.slot_out = 4'(s);
        end else begin
          if (tbl_count >= cap_limit()) begin
            victim = -1;
            oldest = 0;
            for (int i = 0; i < LCP_ENTRIES; i++)
              if (tbl_valid[i] && tbl_pins[i] == 0 && (victim < 0 || tbl_age[i] > oldest)) begin
                victim = i;
                oldest = tbl_age[i];
              end
            if (victim < 0) begin
              r.status = ST_ALL_PINNED;
              return r;
            end
            r.evicted = 1'b1;
            r.evicted_key = tbl_key[victim];
            free_slot(victim);
          end
          s = -1;
          for (int i = 0; i < LCP_ENTRIES && s < 0; i++)
            if (!tbl_valid[i]) s = i;
          if (s < 0) begin
            r.status = ST_ALL_PINNED;
          end else begin
            for (int i = 0; i < LCP_ENTRIES; i++)
              if (tbl_valid[i]) tbl_age[i]++;
            tbl_valid[s] = 1'b1;
            tbl_key[s] = it.key;
            tbl_value[s] = it.value_in;
            tbl_pins[s] = 0;
            tbl_age[s] = 0;
            tbl_count++;
            if (it.take_lock) add_pin(s);
            r.slot_out = 4'(s);
          end
        end
      end
      CMD_LOOKUP: begin
        s = find_slot(it.key);
        if (s < 0) begin
          r.status = ST_MISS;
        end else begin
          r.value_out = tbl_value[s];
          r.slot_out = 4'(s);
          if (it.take_lock) add_pin(s);
          if (it.refresh) make_newest(s);
        end
      end
      CMD_REMOVE: begin
        s = find_slot(it.key);
        if (s < 0) begin
          r.status = ST_MISS;
        end else if (tbl_pins[s] != 0) begin
          r.status = ST_PINNED;
          r.slot_out = 4'(s);
        end else begin
          free_slot(s);
          r.slot_out = 4'(s);
        end
      end
      default: begin
        if (!tbl_valid[it.slot_in] || tbl_pins[it.slot_in] == 0) begin
          r.status = ST_UNPINNED;
        end else begin
          tbl_pins[it.slot_in]--;
          r.slot_out = it.slot_in;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result side: check every accepted beat, then choose the next stall value.
  always @(posedge clk) begin
    lcp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("value_out", want.value_out, out_data.value_out);
        check_field("slot_out", 32'(want.slot_out), 32'(out_data.slot_out));
        check_field("evicted", 32'(want.evicted), 32'(out_data.evicted));
        check_field("evicted_key", want.evicted_key, out_data.evicted_key);
      end
    end
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one command beat and hold it until the core takes it. Valid stays
  // high between back-to-back beats, and only drops for a random gap.
  task automatic send_cmd(lcp_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_results.push_back(cache_response(it));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let the last result leave the core completely.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] v);
    go_idle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cap_setting = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic lcp_in_t make_cmd(logic [1:0] c, logic [31:0] k, logic [31:0] v,
                                       logic lk, logic rf, logic [3:0] sl);
    lcp_in_t it;
    it.cmd = c;
    it.key = k;
    it.value_in = v;
    it.take_lock = lk;
    it.refresh = rf;
    it.slot_in = sl;
    return it;
  endfunction

  // Commands drawn mostly from a small key pool so that hits and duplicates
  // are common; some keys are fully random to exercise misses.
  function automatic lcp_in_t random_cmd();
    lcp_in_t     it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.cmd = (pick < 40) ? CMD_ADD : (pick < 70) ? CMD_LOOKUP :
             (pick < 85) ? CMD_REMOVE : CMD_UNLOCK;
    it.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
    it.value_in = $urandom;
    it.take_lock = ($urandom_range(0, 3) == 0);
    it.refresh = 1'($urandom_range(0, 1));
    it.slot_in = 4'($urandom_range(0, 15));
    return it;
  endfunction

  // Extreme keys and values, every command, hits, misses, pinned remove and
  // the unlock of empty or unpinned slots.
  task automatic test_basic_commands();
    send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 4'd15));
    send_cmd(make_cmd(CMD_ADD, 32'h1234_5678, 32'hA5A5_5A5A, 1'b0, 1'b1, 4'd0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 1'b1, 4'd0));
    send_cmd(make_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_ADD, 32'h0, 32'h5A5A_A5A5, 1'b1, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd1));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd1));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd1));
    send_cmd(make_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd15));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd2));
    send_cmd(make_cmd(CMD_REMOVE, 32'h7777_7777, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_REMOVE, 32'h0, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_REMOVE, 32'h1234_5678, 32'h0, 1'b0, 1'b0, 4'd0));
  endtask

  // Capacity zero behaves as one, an oversized setting as the full table, a
  // table of pinned entries refuses new keys, and a lowered capacity evicts
  // one entry per add.
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_cmd(make_cmd(CMD_ADD, 32'hA, 32'h1, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_ADD, 32'hB, 32'h2, 1'b1, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_ADD, 32'hC, 32'h3, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'd0));
    send_cmd(make_cmd(CMD_REMOVE, 32'hB, 32'h0, 1'b0, 1'b0, 4'd0));
    write_capacity(5'd31);
    for (int i = 0; i < LCP_ENTRIES + 1; i++)
      send_cmd(make_cmd(CMD_ADD, 32'h100 + i, $urandom, 1'b1, 1'b0, 4'd0));
    for (int i = 0; i < LCP_ENTRIES; i += 3)
      send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'(i)));
    write_capacity(5'd2);
    for (int i = 0; i < 4; i++)
      send_cmd(make_cmd(CMD_ADD, 32'h200 + i, $urandom, 1'b0, 1'b0, 4'd0));
    for (int i = 0; i < LCP_ENTRIES; i++)
      send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'(i)));
    for (int i = 0; i < LCP_ENTRIES + 1; i++)
      send_cmd(make_cmd(CMD_REMOVE, 32'h100 + i, 32'h0, 1'b0, 1'b0, 4'd0));
    write_capacity(5'd16);
  endtask

  // Pin one entry past the top of its counter, then drain every pin.
  task automatic test_pin_saturation();
    send_cmd(make_cmd(CMD_ADD, 32'hC0DE, 32'h42, 1'b1, 1'b0, 4'd0));
    for (int i = 0; i < 258; i++)
      send_cmd(make_cmd(CMD_LOOKUP, 32'hC0DE, 32'h0, 1'b1, i[0], 4'd0));
    for (int i = 0; i < 256; i++)
      send_cmd(make_cmd(CMD_UNLOCK, 32'h0, 32'h0, 1'b0, 1'b0, 4'(find_slot(32'hC0DE))));
    send_cmd(make_cmd(CMD_REMOVE, 32'hC0DE, 32'h0, 1'b0, 1'b0, 4'd0));
  endtask

  // The receiver stops for a long stretch while commands keep coming, so the
  // core holds its input stalled; afterwards the sender waits for a full drain.
  // The hold-off is counted in a process of its own.
  task automatic test_backpressure();
    fork
      begin
        hold_on <= 1'b1;
        repeat (150) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    for (int i = 0; i < 8; i++) send_cmd(random_cmd());
    go_idle();
  endtask

  task automatic test_random_traffic();
    logic [4:0] caps[7];
    caps = '{5'd1, 5'd3, 5'd16, 5'd0, 5'd8, 5'd31, 5'd16};
    for (int p = 0; p < 7; p++) begin
      write_capacity(caps[p]);
      for (int i = 0; i < 20; i++) send_cmd(random_cmd());
    end
    // Last part of the run, with no idling on either side.
    quiet = 1'b1;
    for (int i = 0; i < 80; i++) send_cmd(random_cmd());
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    cap_setting = 5'd16;
    tbl_count = 0;
    for (int i = 0; i < LCP_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_value[i] = '0;
      tbl_pins[i] = 0;
      tbl_age[i] = 0;
    end
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_capacity_limits();
    test_pin_saturation();
    test_backpressure();
    test_random_traffic();

    go_idle();
    if (errors == 0) begin
      $display("lru_cache_with_pinning_core_tb passed");
    end else begin
      $display("lru_cache_with_pinning_core_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("lru_cache_with_pinning_core_tb failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lcp_pkg.sv
hdl/lcp_ctrl.sv
hdl/lcp_dp.sv
hdl/lru_cache_with_pinning_core.sv
hdl/lcp_checker.sv
bench/lru_cache_with_pinning_core_tb.sv
